[sv/sstk_pkg.sv]
`default_nettype none

package sstk_pkg;

	// Stack geometry
	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ENTRY_W = 5;

	// Command codes
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;

	// Per-command controls broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
		logic del;
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/sstk_cell.sv]
`default_nettype none

module sstk_cell (
	input  wire logic              clk,
	input  wire sstk_pkg::cell_ctl_t ctl,
	input  wire sstk_pkg::data_t   key,
	input  wire logic              occupied,
	input  wire sstk_pkg::data_t   up_in,
	input  wire sstk_pkg::data_t   down_in,
	input  wire logic              hit_in,
	output sstk_pkg::data_t        value,
	output logic                   hit_out
);

	sstk_pkg::data_t value_q;
	logic            match;

	// Compare the key against this entry and extend the hit chain
	assign match   = occupied && (value_q == key);
	assign hit_out = hit_in | match;
	assign value   = value_q;

	// Take from above on push, from below on pop or at and below a deleted entry
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= up_in;
		end else if (ctl.pop || (ctl.del && hit_out)) begin
			value_q <= down_in;
		end
	end

endmodule

`default_nettype wire

[sv/searchable_stack_with_delete_unit.sv]
`default_nettype none

// Searchable stack with delete.
// Commands enter on start/opcode/operand_value; a beat is taken at a rising
// edge with start high and busy low. Opcodes: push, pop, lookup, delete.
// The entries sit in a row of cells, top first. Each cell compares its entry
// to the operand and passes a "matched above" bit to the cell below, so the
// topmost match is found as the hit bit ripples down the row; push, pop and
// delete move entries one place between neighbors.
// The command is registered at the edge that takes it, the row compares
// in the next cycle, and at the end of that cycle the row shifts and the
// result beat is registered onto done/result_value/status/entry_count.
// busy is high for one cycle after each accepted command, so a new command
// is not taken while the last one is still in the row.
// The clock period is set by the 32-bit compare plus the hit ripple through
// all DEPTH cells.
// Each result beat is shown for exactly one cycle with done high; the
// receiver cannot stall it.
// Reset empties the stack (count zero) and drops any pending command; the
// entry storage itself is not cleared.
module searchable_stack_with_delete_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      opcode,
	input  wire logic signed [31:0]              operand_value,
	output logic                                 done,
	output logic signed [31:0]                   result_value,
	output logic [1:0]                           status,
	output logic [sstk_pkg::ENTRY_W-1:0]         entry_count
);

	logic                        valid_s1;
	logic [1:0]                  op_s1;
	sstk_pkg::data_t             key_s1;
	logic [sstk_pkg::CNT_W-1:0]  count_q;
	logic [sstk_pkg::CNT_W-1:0]  count_d;
	logic                        done_q;
	sstk_pkg::data_t             result_q;
	logic [1:0]                  status_q;
	logic [sstk_pkg::ENTRY_W-1:0] entry_q;

	sstk_pkg::data_t             cell_val [sstk_pkg::DEPTH];
	logic [sstk_pkg::DEPTH-1:0]  cell_hit;
	sstk_pkg::cell_ctl_t         ctl;
	logic                        full;
	logic                        empty;
	logic                        found;
	sstk_pkg::data_t             res_d;
	logic [1:0]                  status_d;

	assign busy = valid_s1;

	// Capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1  <= opcode;
			key_s1 <= operand_value;
		end
	end

	assign full  = (count_q == sstk_pkg::CNT_W'(sstk_pkg::DEPTH));
	assign empty = (count_q == '0);
	assign found = cell_hit[sstk_pkg::DEPTH-1];

	// Drive the cell controls
	always_comb begin
		ctl.push = valid_s1 && (op_s1 == sstk_pkg::OP_PUSH) && !full;
		ctl.pop  = valid_s1 && (op_s1 == sstk_pkg::OP_POP) && !empty;
		ctl.del  = valid_s1 && (op_s1 == sstk_pkg::OP_DELETE);
	end

	// Row of cells, top at index 0
	for (genvar i = 0; i < sstk_pkg::DEPTH; i++) begin : g_cell
		sstk_pkg::data_t up_w;
		sstk_pkg::data_t down_w;
		logic            hit_w;
		logic            occ_w;

		if (i == 0) begin : g_top
			assign up_w  = key_s1;
			assign hit_w = 1'b0;
		end else begin : g_mid
			assign up_w  = cell_val[i-1];
			assign hit_w = cell_hit[i-1];
		end

		if (i == sstk_pkg::DEPTH - 1) begin : g_bot
			assign down_w = cell_val[i];
		end else begin : g_nbot
			assign down_w = cell_val[i+1];
		end

		assign occ_w = (sstk_pkg::CNT_W'(i) < count_q);

		sstk_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.key      (key_s1),
			.occupied (occ_w),
			.up_in    (up_w),
			.down_in  (down_w),
			.hit_in   (hit_w),
			.value    (cell_val[i]),
			.hit_out  (cell_hit[i])
		);
	end

	// Form the result and the next count
	always_comb begin
		res_d    = '0;
		status_d = sstk_pkg::ST_OK;
		count_d  = count_q;
		case (op_s1)
			sstk_pkg::OP_PUSH: begin
				if (full) begin
					status_d = sstk_pkg::ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			sstk_pkg::OP_POP: begin
				if (empty) begin
					status_d = sstk_pkg::ST_MISS;
				end else begin
					res_d   = cell_val[0];
					count_d = count_q - 1'b1;
				end
			end
			sstk_pkg::OP_LOOKUP: begin
				if (found) begin
					res_d = key_s1;
				end else begin
					status_d = sstk_pkg::ST_MISS;
				end
			end
			sstk_pkg::OP_DELETE: begin
				if (found) begin
					count_d = count_q - 1'b1;
				end else begin
					status_d = sstk_pkg::ST_MISS;
				end
			end
			default: begin
				status_d = sstk_pkg::ST_MISS;
			end
		endcase
	end

	// Advance count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				count_q <= count_d;
			end
		end
	end

	// Hold the result beat payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_d;
			status_q <= status_d;
			entry_q  <= sstk_pkg::ENTRY_W'(count_d);
		end
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign entry_count  = entry_q;

	a_cmd_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("command did not produce a result beat");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat overlaps a pending command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sstk_pkg::CNT_W'(sstk_pkg::DEPTH))
		else $error("count exceeds depth");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && full && (op_s1 == sstk_pkg::OP_PUSH)) |=> (count_q == $past(count_q)))
		else $error("push when full changed the count");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == sstk_pkg::ST_MISS)) |-> (result_value == '0))
		else $error("miss carries a nonzero value");

endmodule

`default_nettype wire

[verif/searchable_stack_with_delete_unit_tb.sv]
`default_nettype none

module searchable_stack_with_delete_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 400;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_CMDS = 650;

	typedef struct {
		sstk_pkg::data_t              value;
		logic [1:0]                   st;
		logic [sstk_pkg::ENTRY_W-1:0] cnt;
	} stack_reply_t;

	// Mirror of the stack contents and the replies still owed by the block
	class stack_scoreboard;
		sstk_pkg::data_t slots[sstk_pkg::DEPTH];
		int unsigned     used;
		stack_reply_t    owed[$];
		int              errors;
		int              n_cmds;
		int              n_beats;
		int              n_full;
		int              n_del_hits;

		function new();
			used = 0;
			errors = 0;
			n_cmds = 0;
			n_beats = 0;
			n_full = 0;
			n_del_hits = 0;
		endfunction

		// Position of the topmost entry equal to v, or used on a miss
		function int unsigned top_match(sstk_pkg::data_t v);
			for (int unsigned i = 0; i < used; i++) begin
				if (slots[i] == v)
					return i;
			end
			return used;
		endfunction

		function sstk_pkg::data_t pick_stored();
			return slots[$urandom_range(0, used - 1)];
		endfunction

		// Apply one accepted command and queue the reply it must produce
		function void note_cmd(logic [1:0] op, sstk_pkg::data_t val);
			stack_reply_t r;
			int unsigned  pos;
			r.value = '0;
			r.st = sstk_pkg::ST_OK;
			pos = top_match(val);
			case (op)
				sstk_pkg::OP_PUSH: begin
					if (used >= sstk_pkg::DEPTH) begin
						r.st = sstk_pkg::ST_FULL;
						n_full++;
					end else begin
						for (int unsigned i = used; i > 0; i--)
							slots[i] = slots[i-1];
						slots[0] = val;
						used++;
					end
				end
				sstk_pkg::OP_POP: begin
					if (used == 0) begin
						r.st = sstk_pkg::ST_MISS;
					end else begin
						r.value = slots[0];
						for (int unsigned i = 0; i + 1 < used; i++)
							slots[i] = slots[i+1];
						used--;
					end
				end
				sstk_pkg::OP_LOOKUP: begin
					if (pos < used)
						r.value = val;
					else
						r.st = sstk_pkg::ST_MISS;
				end
				default: begin
					if (pos >= used) begin
						r.st = sstk_pkg::ST_MISS;
					end else begin
						for (int unsigned i = pos; i + 1 < used; i++)
							slots[i] = slots[i+1];
						used--;
						n_del_hits++;
					end
				end
			endcase
			r.cnt = used[sstk_pkg::ENTRY_W-1:0];
			owed.push_back(r);
			n_cmds++;
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
			errors++;
		endtask

		// Compare one result beat with the oldest owed reply
		task check_reply(sstk_pkg::data_t rv, logic [1:0] st,
				logic [sstk_pkg::ENTRY_W-1:0] cnt);
			stack_reply_t want;
			n_beats++;
			if (owed.size() == 0) begin
				report_mismatch("unexpected result beat", rv, '0);
			end else begin
				want = owed.pop_front();
				if (rv !== want.value)
					report_mismatch("result_value", rv, want.value);
				if (st !== want.st)
					report_mismatch("status", 32'(st), 32'(want.st));
				if (cnt !== want.cnt)
					report_mismatch("entry_count", 32'(cnt), 32'(want.cnt));
			end
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   opcode;
	logic signed [31:0]           operand_value;
	logic                         done;
	logic signed [31:0]           result_value;
	logic [1:0]                   status;
	logic [sstk_pkg::ENTRY_W-1:0] entry_count;

	stack_scoreboard sb;
	bit              no_gaps;
	int              stall_run = 0;

	searchable_stack_with_delete_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.operand_value (operand_value),
		.done          (done),
		.result_value  (result_value),
		.status        (status),
		.entry_count   (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Check every result beat against the predicted reply
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_reply(result_value, status, entry_count);
	end

	// Abort when neither side moves a beat for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_run <= 0;
		else
			stall_run <= stall_run + 1;
		if (stall_run >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Present one command, hold it until taken, then note it
	task automatic send_cmd(input logic [1:0] op, input sstk_pkg::data_t val);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		operand_value <= val;
		do
			@(posedge clk);
		while (busy);
		sb.note_cmd(op, val);
	endtask

	// Mix stored values, a small clash-prone pool, extremes and raw noise
	function automatic sstk_pkg::data_t pick_operand();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r <= 2 && sb.used > 0)
			return sb.pick_stored();
		if (r <= 4)
			return sstk_pkg::data_t'($urandom_range(0, 4)) - 2;
		if (r == 5)
			return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		return sstk_pkg::data_t'($urandom);
	endfunction

	// Weight opcodes by phase: fill, drain, or an even mix
	function automatic logic [1:0] pick_op(int mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (mode)
			0: return (r < 75) ? sstk_pkg::OP_PUSH :
				(r < 85) ? sstk_pkg::OP_LOOKUP :
				(r < 93) ? sstk_pkg::OP_DELETE : sstk_pkg::OP_POP;
			1: return (r < 40) ? sstk_pkg::OP_POP :
				(r < 75) ? sstk_pkg::OP_DELETE :
				(r < 90) ? sstk_pkg::OP_LOOKUP : sstk_pkg::OP_PUSH;
			default: return 2'($urandom_range(0, 3));
		endcase
	endfunction

	initial begin
		int sent;
		int run_len;
		int mode;
		sb = new();
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = sstk_pkg::OP_PUSH;
		operand_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: pop, delete and lookup all miss
		send_cmd(sstk_pkg::OP_POP, 32'sd0);
		send_cmd(sstk_pkg::OP_DELETE, 32'sd7);
		send_cmd(sstk_pkg::OP_LOOKUP, 32'sd0);
		// Extremes, with a duplicate of the minimum on top
		send_cmd(sstk_pkg::OP_PUSH, 32'sh8000_0000);
		send_cmd(sstk_pkg::OP_PUSH, 32'sh7fff_ffff);
		send_cmd(sstk_pkg::OP_PUSH, -32'sd1);
		send_cmd(sstk_pkg::OP_PUSH, 32'sd0);
		send_cmd(sstk_pkg::OP_PUSH, 32'sh8000_0000);
		// Hit deep, miss, hit at top
		send_cmd(sstk_pkg::OP_LOOKUP, 32'sh7fff_ffff);
		send_cmd(sstk_pkg::OP_LOOKUP, 32'sd1);
		send_cmd(sstk_pkg::OP_LOOKUP, 32'sh8000_0000);
		// Delete only the topmost duplicate, the lower copy must remain
		send_cmd(sstk_pkg::OP_DELETE, 32'sh8000_0000);
		send_cmd(sstk_pkg::OP_LOOKUP, 32'sh8000_0000);
		send_cmd(sstk_pkg::OP_DELETE, 32'sd12345);
		// Delete from the middle and close the gap
		send_cmd(sstk_pkg::OP_DELETE, -32'sd1);
		// Drain through to an empty pop
		send_cmd(sstk_pkg::OP_POP, 32'sd0);
		send_cmd(sstk_pkg::OP_POP, 32'sd99);
		send_cmd(sstk_pkg::OP_POP, -32'sd5);
		send_cmd(sstk_pkg::OP_POP, 32'sd0);
		// Alternating bit patterns
		send_cmd(sstk_pkg::OP_PUSH, 32'sh5555_5555);
		send_cmd(sstk_pkg::OP_PUSH, 32'shaaaa_aaaa);
		send_cmd(sstk_pkg::OP_POP, 32'sh5555_5555);
		send_cmd(sstk_pkg::OP_POP, 32'shaaaa_aaaa);

		// Random phases of varying bias and pacing
		sent = 0;
		while (sent < RANDOM_CMDS) begin
			run_len = $urandom_range(20, 60);
			mode = $urandom_range(0, 2);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (run_len) begin
				send_cmd(pick_op(mode), pick_operand());
				sent++;
			end
		end
		start <= 1'b0;

		// Collect what is still owed, then watch for stray beats
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d commands and %0d result beats", sb.n_cmds, sb.n_beats);
		$display("%0d pushes refused when full, %0d deletes that removed an entry",
			sb.n_full, sb.n_del_hits);
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
sv/sstk_pkg.sv
sv/sstk_cell.sv
sv/searchable_stack_with_delete_unit.sv
verif/searchable_stack_with_delete_unit_tb.sv
